// File: rtl/rll_pkg.sv
`default_nettype none

package rll_pkg;

   // fourcc codes, first character in the low byte
   localparam logic [31:0] FOURCC_RIFF = 32'h4646_4952;
   localparam logic [31:0] FOURCC_AVI  = 32'h2049_5641;
   localparam logic [31:0] FOURCC_LIST = 32'h5453_494C;

   localparam int HDR_BYTES       = 8;
   localparam int LIST_TYPE_BYTES = 4;

   localparam logic [31:0] TARGET_LIST_TYPE_RESET = 32'h6C72_6468;
   localparam logic [31:0] FILE_LENGTH_RESET      = 32'h0000_0000;

   // byte positions inside the 12-byte riff header and the 8-byte element header
   localparam logic [3:0] IDX_TAG_LAST   = 4'd3;
   localparam logic [3:0] IDX_SIZE_FIRST = 4'd4;
   localparam logic [3:0] IDX_SIZE_LAST  = 4'd7;
   localparam logic [3:0] IDX_FORM_LAST  = 4'd11;

   typedef enum logic [0:0] {
      CSR_TARGET_LIST_TYPE = 1'b0,
      CSR_FILE_LENGTH      = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_FOUND     = 3'd0,
      ST_NOT_RIFF  = 3'd1,
      ST_BAD_SIZE  = 3'd2,
      ST_NOT_AVI   = 3'd3,
      ST_OVERRUN   = 3'd4,
      ST_TRUNCATED = 3'd5,
      ST_NOT_FOUND = 3'd6
   } status_type;

   typedef enum logic [4:0] {
      PH_RIFF = 5'b00001,
      PH_HDR  = 5'b00010,
      PH_TYPE = 5'b00100,
      PH_SKIP = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } req_stage_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] payload_offset;
      logic [31:0] payload_size;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } result_type;

   typedef struct packed {
      logic [31:0] target_list_type;
      logic [31:0] file_length;
   } cfg_type;

   // place a byte at its little-endian lane of a 32-bit word
   function automatic logic [31:0] byte_lane(input logic [7:0] value, input logic [1:0] pos);
      byte_lane = {24'd0, value} << {pos, 3'b000};
   endfunction

endpackage

`default_nettype wire

// File: rtl/rll_req_if.sv
`default_nettype none

interface rll_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

`default_nettype wire

// File: rtl/rll_rsp_if.sv
`default_nettype none

interface rll_rsp_if;
   import rll_pkg::*;

   logic        valid;
   logic        ready;
   status_type  status;
   logic [31:0] payload_offset;
   logic [31:0] payload_size;

   modport source (output valid, output status, output payload_offset, output payload_size,
                   input ready);
   modport sink (input valid, input status, input payload_offset, input payload_size,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/rll_csr_if.sv
`default_nettype none

interface rll_csr_if;
   import rll_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [31:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/rll_req_reg.sv
`default_nettype none

module rll_req_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   output rll_pkg::req_stage_type stage,
   rll_req_if.sink               req_chan
);
   import rll_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         accept;

   // refill in the same cycle the walker takes the held byte
   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data_byte <= req_chan.data_byte;
         item_ff.is_last   <= req_chan.is_last;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

// File: rtl/rll_walker.sv
`default_nettype none

module rll_walker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  rll_pkg::req_stage_type stage,
   input  rll_pkg::cfg_type       cfg,
   output rll_pkg::result_type    result
);
   import rll_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [3:0]         idx_ff, idx_in;
   logic [31:0]        word_ff, word_in;
   logic [31:0]        esize_ff, esize_in;
   logic [31:0]        offset_ff, offset_in;
   logic signed [33:0] rem_ff, rem_in;
   logic signed [33:0] rem_hdr, rem_type;
   logic [32:0]        skip_ff, skip_in, skip_pad;
   logic               list_ff, list_in;
   logic [31:0]        lane;
   logic               decided, truncated;
   status_type         dec_status;
   logic [31:0]        poff, psize;

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      word_in    = word_ff;
      esize_in   = esize_ff;
      rem_in     = rem_ff;
      skip_in    = skip_ff;
      list_in    = list_ff;
      offset_in  = offset_ff + 32'd1;
      skip_pad   = '0;
      decided    = 1'b0;
      truncated  = 1'b0;
      dec_status = ST_FOUND;
      poff       = '0;
      psize      = '0;
      lane       = byte_lane(stage.item.data_byte, idx_ff[1:0]);
      rem_hdr    = rem_ff - 34'(HDR_BYTES);
      rem_type   = rem_ff - 34'(LIST_TYPE_BYTES);

      unique case (phase_ff)
         PH_RIFF: begin
            idx_in = idx_ff + 4'd1;
            if (idx_ff < IDX_SIZE_FIRST) begin
               word_in = word_ff | lane;
               if (idx_ff == IDX_TAG_LAST && word_in != FOURCC_RIFF) begin
                  decided    = 1'b1;
                  dec_status = ST_NOT_RIFF;
               end
            end else if (idx_ff <= IDX_SIZE_LAST) begin
               esize_in = ((idx_ff == IDX_SIZE_FIRST) ? 32'd0 : esize_ff) | lane;
               if (idx_ff == IDX_SIZE_LAST) begin
                  word_in = '0;
                  if (({1'b0, esize_in} + 33'(HDR_BYTES)) != {1'b0, cfg.file_length}) begin
                     decided    = 1'b1;
                     dec_status = ST_BAD_SIZE;
                  end else begin
                     rem_in = $signed({2'b00, esize_in}) - 34'(LIST_TYPE_BYTES);
                  end
               end
            end else begin
               word_in = word_ff | lane;
               if (idx_ff == IDX_FORM_LAST) begin
                  if (word_in != FOURCC_AVI) begin
                     decided    = 1'b1;
                     dec_status = ST_NOT_AVI;
                  end else begin
                     phase_in = PH_HDR;
                     idx_in   = '0;
                     word_in  = '0;
                  end
               end
            end
         end
         PH_HDR: begin
            idx_in = idx_ff + 4'd1;
            if (idx_ff < IDX_SIZE_FIRST) begin
               word_in = word_ff | lane;
               if (idx_ff == IDX_TAG_LAST) begin
                  esize_in = '0;
               end
            end else begin
               esize_in = esize_ff | lane;
               if (idx_ff == IDX_SIZE_LAST) begin
                  rem_in  = rem_hdr;
                  list_in = (word_ff == FOURCC_LIST);
                  if (rem_hdr < $signed({2'b00, esize_in})) begin
                     decided    = 1'b1;
                     dec_status = ST_OVERRUN;
                  end else if (list_in) begin
                     if (esize_in < 32'(LIST_TYPE_BYTES)) begin
                        decided    = 1'b1;
                        dec_status = ST_OVERRUN;
                     end else begin
                        phase_in = PH_TYPE;
                        word_in  = '0;
                        idx_in   = '0;
                     end
                  end else begin
                     // chunks are padded to even length
                     skip_pad = {1'b0, esize_in} + {32'd0, esize_in[0]};
                     skip_in  = skip_pad;
                     rem_in   = rem_hdr - $signed({1'b0, skip_pad});
                     if (esize_in == '0) begin
                        if (rem_in > 34'sd0) begin
                           phase_in = PH_HDR;
                           idx_in   = '0;
                           word_in  = '0;
                        end else begin
                           decided    = 1'b1;
                           dec_status = ST_NOT_FOUND;
                        end
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
            end
         end
         PH_TYPE: begin
            word_in = word_ff | lane;
            idx_in  = idx_ff + 4'd1;
            if (idx_ff == IDX_TAG_LAST) begin
               rem_in = rem_type;
               if (word_in == cfg.target_list_type) begin
                  decided    = 1'b1;
                  dec_status = ST_FOUND;
                  poff       = offset_in;
                  psize      = esize_ff - 32'(LIST_TYPE_BYTES);
               end else begin
                  skip_in = {1'b0, esize_ff - 32'(LIST_TYPE_BYTES)};
                  rem_in  = rem_type - $signed({1'b0, skip_in});
                  if (esize_ff == 32'(LIST_TYPE_BYTES)) begin
                     if (rem_in > 34'sd0) begin
                        phase_in = PH_HDR;
                        idx_in   = '0;
                        word_in  = '0;
                     end else begin
                        decided    = 1'b1;
                        dec_status = ST_NOT_FOUND;
                     end
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 33'd1;
            if (skip_in == '0) begin
               if (rem_ff > 34'sd0) begin
                  phase_in = PH_HDR;
                  idx_in   = '0;
                  word_in  = '0;
               end else begin
                  decided    = 1'b1;
                  dec_status = ST_NOT_FOUND;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (decided) begin
         phase_in = PH_DONE;
      end else if (stage.item.is_last && phase_ff != PH_DONE) begin
         truncated  = 1'b1;
         dec_status = ST_TRUNCATED;
      end

      // end of file rearms the walker
      if (stage.item.is_last) begin
         phase_in  = PH_RIFF;
         idx_in    = '0;
         word_in   = '0;
         esize_in  = '0;
         rem_in    = '0;
         skip_in   = '0;
         offset_in = '0;
         list_in   = 1'b0;
      end

      result.valid               = advance && (decided || truncated);
      result.item.status         = dec_status;
      result.item.payload_offset = poff;
      result.item.payload_size   = psize;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_RIFF;
         idx_ff    <= '0;
         word_ff   <= '0;
         esize_ff  <= '0;
         rem_ff    <= '0;
         skip_ff   <= '0;
         offset_ff <= '0;
         list_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         word_ff   <= word_in;
         esize_ff  <= esize_in;
         rem_ff    <= rem_in;
         skip_ff   <= skip_in;
         offset_ff <= offset_in;
         list_ff   <= list_in;
      end
   end

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      advance && stage.item.is_last |=> phase_ff == PH_RIFF && idx_ff == '0 && offset_ff == '0)
      else $error("walker did not rearm after last byte");

   a_found_from_type: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.item.status == ST_FOUND |->
         phase_ff == PH_TYPE && idx_ff == IDX_TAG_LAST)
      else $error("found status outside the list type field");

   a_quiet_when_done: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_DONE && !stage.item.is_last |-> !result.valid)
      else $error("second result within one file");

   a_type_of_list: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TYPE |-> list_ff && esize_ff >= 32'(LIST_TYPE_BYTES))
      else $error("list type read for an element that is not a valid list");

endmodule

`default_nettype wire

// File: rtl/rll_rsp_reg.sv
`default_nettype none

module rll_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  rll_pkg::result_type result,
   output logic                slot_free,
   rll_rsp_if.source           rsp_chan
);
   import rll_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         item_ff <= result.item;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.status         = item_ff.status;
   assign rsp_chan.payload_offset = item_ff.payload_offset;
   assign rsp_chan.payload_size   = item_ff.payload_size;

endmodule

`default_nettype wire

// File: rtl/riff_list_locator_core.sv
// riff list locator: takes an avi file one byte per request (data_byte, is_last on the
// final byte) and answers with at most one response per file: the offset and size of the
// payload of the first top-level LIST whose type matches target_list_type, or an error
// status (not riff, bad size, not avi, element overrun, truncated, not found). The riff
// size must equal file_length minus 8. A byte is accepted every cycle while the response
// register can take a result; the deciding byte passes the request register, then the
// walker, whose result is written into the response register, and one walker update per
// byte sets that rate. A pending response does not stop new bytes as long as the response
// register drains. Bytes after a decision are ignored until is_last, which rearms the
// walker for the next file. Program target_list_type and file_length only while idle.
`default_nettype none

module riff_list_locator_core (
   input  logic      clock,
   input  logic      reset,
   rll_req_if.sink   req_chan,
   rll_rsp_if.source rsp_chan,
   rll_csr_if.sink   csr_chan
);
   import rll_pkg::*;

   // configuration registers
   logic [31:0] target_ff, target_in;
   logic [31:0] length_ff, length_in;
   cfg_type     cfg;

   req_stage_type stage;
   result_type    result;
   logic          slot_free;
   logic          advance;

   // writes are always taken
   assign csr_chan.ready = 1'b1;

   always_comb begin
      target_in = target_ff;
      length_in = length_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_TARGET_LIST_TYPE: target_in = csr_chan.data;
            CSR_FILE_LENGTH:      length_in = csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_LIST_TYPE_RESET;
         length_ff <= FILE_LENGTH_RESET;
      end else begin
         target_ff <= target_in;
         length_ff <= length_in;
      end
   end

   assign cfg.target_list_type = target_ff;
   assign cfg.file_length      = length_ff;

   // the walker steps when a byte is held and the response slot can take a result
   assign advance = stage.valid && slot_free;

   // request register
   rll_req_reg u_req_reg (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .stage    (stage),
      .req_chan (req_chan)
   );

   // header parse and element walk, one byte per step
   rll_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .stage   (stage),
      .cfg     (cfg),
      .result  (result)
   );

   // response register
   rll_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
